// ===== rtl/max_pool_2d_stream_top_defines.svh =====
// Assertion macros shared by the max pooling RTL.
`ifndef MAX_POOL_2D_STREAM_TOP_DEFINES_SVH
`define MAX_POOL_2D_STREAM_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MP2S_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MP2S_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mp2s_pkg.sv =====
// Package with register indexes, field widths and helpers for the max pooling block.
package mp2s_pkg;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_CHANNEL_COUNT = 3'd2,
      CSR_POOL_ROWS     = 3'd3,
      CSR_POOL_COLS     = 3'd4
   } csr_index_type;

   localparam int unsigned CSR_DATA_W   = 13;
   localparam int unsigned WIDTH_REG_W  = 9;
   localparam int unsigned HEIGHT_REG_W = 13;
   localparam int unsigned CHAN_REG_W   = 4;
   localparam int unsigned POOL_REG_W   = 4;
   localparam int unsigned ROW_W        = 12;
   localparam int unsigned MAX_HEIGHT   = 4096;

   localparam int unsigned RST_WIDTH    = 256;
   localparam int unsigned RST_HEIGHT   = 256;
   localparam int unsigned RST_CHANNELS = 1;
   localparam int unsigned RST_POOL     = 2;

   function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
      int unsigned r;
      if (v == 0) begin
         r = 1;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/max_pool_2d_stream_top.sv =====
// Top level of the streaming non-overlapping 2-D max pooling block.
//
// Samples enter on the req_ stream in raster order, channels innermost, one
// signed fixed-point value per transaction. Each image is cut into windows of
// pool_rows x pool_cols pixels with a stride equal to the window size; windows
// cut short by the right or bottom border are pooled over what they hold.
// The sample that completes a window produces one rsp_ transaction carrying
// that window's maximum for its channel; rsp_tlast marks the last result of
// the image. Frames follow one another without a gap.
// Running maxima live in one memory with one entry per window column and
// channel, read at the edge that takes a sample and written back when the
// memory stage advances. Back-to-back updates of the same entry are forwarded.
// A result passes the memory stage, then the output register, onto rsp_;
// one sample per cycle is taken while the output register drains.
// When rsp_tready is low, one result waits in the output register, the
// memory stage holds a second result; req_tready drops only once both are full.
// Reset clears the position counters and loads the register defaults; the
// memory is not cleared. Any csr_ write restarts the frame position.
`include "max_pool_2d_stream_top_defines.svh"

module max_pool_2d_stream_top
   import mp2s_pkg::*;
#(
   parameter int unsigned MAX_WIDTH    = 256,
   parameter int unsigned MAX_CHANNELS = 8,
   parameter int unsigned MAX_POOL     = 8,
   parameter int unsigned SAMPLE_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // sample
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,  // max_value
   output logic                                   rsp_tlast,
   input  logic                                   csr_we,
   input  logic [2:0]                             csr_index,
   input  logic [CSR_DATA_W-1:0]                  csr_wdata
);

   localparam int unsigned TD_W   = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int unsigned DEPTH  = MAX_WIDTH * MAX_CHANNELS;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int unsigned PW     = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;

   logic [COL_W-1:0]        w_last_ff, w_last_in;
   logic [ROW_W-1:0]        h_last_ff, h_last_in;
   logic [CH_W-1:0]         c_last_ff, c_last_in;
   logic [PW-1:0]           pr_last_ff, pr_last_in;
   logic [PW-1:0]           pc_last_ff, pc_last_in;

   logic [ROW_W-1:0]        row_count_ff, row_count_in;
   logic [COL_W-1:0]        col_count_ff, col_count_in;
   logic [CH_W-1:0]         chan_count_ff, chan_count_in;
   logic [PW-1:0]           row_in_win_ff, row_in_win_in;
   logic [PW-1:0]           col_in_win_ff, col_in_win_in;
   logic [COL_W-1:0]        win_col_ff, win_col_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]       s1_addr_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                    s1_first_ff;
   logic                    s1_emit_ff;
   logic                    s1_frame_end_ff;
   logic                    s1_fwd_ff;
   logic signed [SAMPLE_BITS-1:0] last_max_ff;
   logic signed [SAMPLE_BITS-1:0] ram_rd_ff;

   logic                    out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0]  out_data_ff;
   logic                    out_last_ff;

   logic [SAMPLE_BITS-1:0]  mem [DEPTH];

   logic                    accept;
   logic                    s1_adv;
   logic [ADDR_W-1:0]       addr;
   logic                    last_row, last_col, last_chan;
   logic                    win_row_end, win_col_end;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic signed [SAMPLE_BITS-1:0] s1_prev;
   logic signed [SAMPLE_BITS-1:0] s1_max;

   assign sample      = req_tdata[SAMPLE_BITS-1:0];
   assign s1_adv      = s1_valid_ff && (!s1_emit_ff || !out_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign accept      = req_tvalid && req_tready;

   assign last_row    = (row_count_ff == h_last_ff);
   assign last_col    = (col_count_ff == w_last_ff);
   assign last_chan   = (chan_count_ff == c_last_ff);
   assign win_row_end = last_row || (row_in_win_ff == pr_last_ff);
   assign win_col_end = last_col || (col_in_win_ff == pc_last_ff);
   assign addr = ADDR_W'(ADDR_W'(win_col_ff) * ADDR_W'(MAX_CHANNELS)) + ADDR_W'(chan_count_ff);

   assign s1_prev = s1_fwd_ff ? last_max_ff : ram_rd_ff;
   assign s1_max  = (s1_first_ff || (s1_sample_ff > s1_prev)) ? s1_sample_ff : s1_prev;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TD_W'(out_data_ff);
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      w_last_in     = w_last_ff;
      h_last_in     = h_last_ff;
      c_last_in     = c_last_ff;
      pr_last_in    = pr_last_ff;
      pc_last_in    = pc_last_ff;
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      chan_count_in = chan_count_ff;
      row_in_win_in = row_in_win_ff;
      col_in_win_in = col_in_win_ff;
      win_col_in    = win_col_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               w_last_in = COL_W'(clamp_reg(32'(csr_wdata[WIDTH_REG_W-1:0]), MAX_WIDTH) - 1);
            end
            CSR_IMAGE_HEIGHT: begin
               h_last_in = ROW_W'(clamp_reg(32'(csr_wdata[HEIGHT_REG_W-1:0]), MAX_HEIGHT) - 1);
            end
            CSR_CHANNEL_COUNT: begin
               c_last_in = CH_W'(clamp_reg(32'(csr_wdata[CHAN_REG_W-1:0]), MAX_CHANNELS) - 1);
            end
            CSR_POOL_ROWS: begin
               pr_last_in = PW'(clamp_reg(32'(csr_wdata[POOL_REG_W-1:0]), MAX_POOL) - 1);
            end
            CSR_POOL_COLS: begin
               pc_last_in = PW'(clamp_reg(32'(csr_wdata[POOL_REG_W-1:0]), MAX_POOL) - 1);
            end
            default: begin
            end
         endcase
         row_count_in  = '0;
         col_count_in  = '0;
         chan_count_in = '0;
         row_in_win_in = '0;
         col_in_win_in = '0;
         win_col_in    = '0;
      end else if (accept) begin
         if (!last_chan) begin
            chan_count_in = chan_count_ff + 1'b1;
         end else begin
            chan_count_in = '0;
            if (!last_col) begin
               col_count_in = col_count_ff + 1'b1;
               if (col_in_win_ff == pc_last_ff) begin
                  col_in_win_in = '0;
                  win_col_in    = win_col_ff + 1'b1;
               end else begin
                  col_in_win_in = col_in_win_ff + 1'b1;
               end
            end else begin
               col_count_in  = '0;
               col_in_win_in = '0;
               win_col_in    = '0;
               if (last_row) begin
                  row_count_in  = '0;
                  row_in_win_in = '0;
               end else begin
                  row_count_in  = row_count_ff + 1'b1;
                  row_in_win_in = (row_in_win_ff == pr_last_ff) ? '0 : row_in_win_ff + 1'b1;
               end
            end
         end
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_adv && s1_emit_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff     <= COL_W'(clamp_reg(RST_WIDTH, MAX_WIDTH) - 1);
         h_last_ff     <= ROW_W'(clamp_reg(RST_HEIGHT, MAX_HEIGHT) - 1);
         c_last_ff     <= CH_W'(clamp_reg(RST_CHANNELS, MAX_CHANNELS) - 1);
         pr_last_ff    <= PW'(clamp_reg(RST_POOL, MAX_POOL) - 1);
         pc_last_ff    <= PW'(clamp_reg(RST_POOL, MAX_POOL) - 1);
         row_count_ff  <= '0;
         col_count_ff  <= '0;
         chan_count_ff <= '0;
         row_in_win_ff <= '0;
         col_in_win_ff <= '0;
         win_col_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         w_last_ff     <= w_last_in;
         h_last_ff     <= h_last_in;
         c_last_ff     <= c_last_in;
         pr_last_ff    <= pr_last_in;
         pc_last_ff    <= pc_last_in;
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         chan_count_ff <= chan_count_in;
         row_in_win_ff <= row_in_win_in;
         col_in_win_ff <= col_in_win_in;
         win_col_ff    <= win_col_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff      <= addr;
         s1_sample_ff    <= sample;
         s1_first_ff     <= (row_in_win_ff == '0) && (col_in_win_ff == '0);
         s1_emit_ff      <= win_row_end && win_col_end;
         s1_frame_end_ff <= last_row && last_col && last_chan;
         s1_fwd_ff       <= s1_adv && (addr == s1_addr_ff);
      end
      if (s1_adv) begin
         last_max_ff <= s1_max;
      end
      if (s1_adv && s1_emit_ff) begin
         out_data_ff <= s1_max;
         out_last_ff <= s1_frame_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         mem[s1_addr_ff] <= s1_max;
      end
      if (accept) begin
         ram_rd_ff <= mem[addr];
      end
   end

   `MP2S_ASSERT_IMP(a_accept_slot_free, clock, reset, accept, !s1_valid_ff || s1_adv,
      "sample accepted while the memory stage is blocked")
   `MP2S_ASSERT_NXT(a_read_data_held, clock, reset, s1_valid_ff && !s1_adv, $stable(ram_rd_ff),
      "memory read data changed while the memory stage was stalled")
   `MP2S_ASSERT_IMP(a_result_has_room, clock, reset, s1_adv && s1_emit_ff,
      !out_valid_ff || rsp_tready, "result overwrote an untaken output")
   `MP2S_ASSERT_NXT(a_forward_same_entry, clock, reset, accept && s1_adv && (addr == s1_addr_ff),
      s1_fwd_ff, "back-to-back update of one entry was not forwarded")
   `MP2S_ASSERT_IMP(a_position_in_range, clock, reset, 1'b1,
      (col_count_ff <= w_last_ff) && (chan_count_ff <= c_last_ff),
      "pixel position outside the configured image")

endmodule
